/* hw/rtl/stme_pkg.sv */
`timescale 1ns / 1ps

package stme_pkg;

  localparam int MAX_DIM_DEF    = 16;
  localparam int MAX_NNZ_DEF    = 256;
  localparam int VALUE_BITS_DEF = 16;

  // fixed port widths
  localparam int CFG_W   = 5;
  localparam int CIDX_W  = 3;
  localparam int OUT_W   = 40;
  localparam int OIDX_W  = 4;
  localparam int ELEM_W  = 16;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_FETCH = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] OP_ADD       = 2'd0;
  localparam logic [1:0] OP_TRANSPOSE = 2'd1;
  localparam logic [1:0] OP_MULTIPLY  = 2'd2;

  localparam logic [CIDX_W-1:0] REG_OPERATION = 3'd0;
  localparam logic [CIDX_W-1:0] REG_ROWS_A    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_COLS_A    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_ROWS_B    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_COLS_B    = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_DIV, S_LD_WR, S_F_CHK, S_F_RD, S_F_OUT,
    S_T_CLR, S_T_CNT_RD, S_T_CNT_GET, S_T_CNT_WR, S_T_PRE_RD, S_T_PRE_WR,
    S_T_PL_RD, S_T_PL_GET, S_T_PL_WR, S_CP_RD, S_CP_WR, S_AD_RD, S_AD_CMP,
    S_M_ROW_RD, S_M_ROW, S_M_COL_RD, S_M_COL, S_M_DOT_RD, S_M_DOT_CMP,
    S_M_DOT_ACC, S_M_PUSH, S_M_JSK_RD, S_M_JSK, S_M_ISK_RD, S_M_ISK
  } state_t;

endpackage

/* hw/rtl/sparse_triplet_matrix_engine_core.sv */
`timescale 1ns / 1ps

// Sparse triplet matrix engine: A + B, B transposed, A * B on triplet stores.
// Command channel: a command transfers when start is high and busy is low.
//   action load  : one dense element (row-major) into A (matrix_sel 0) or B.
//                  Zeros are dropped; loads past rows*cols are ignored.
//                  A bit-serial divider splits the position into row and
//                  column before the write.
//   action fetch : returns one result triplet on valid, through S_F_CHK,
//                  S_F_RD and S_F_OUT when the result is already built. The
//                  first fetch after a load, clear or register write first
//                  builds the whole result by walking the stores with one
//                  shared sequencer.
//   action clear : empties the stores; registers are kept.
// Register port: wr_en/wr_index/wr_data, written by the user only while idle;
// the block does not enforce it. Results sit on the output ports for exactly
// one cycle with valid high; the receiver cannot stall. empty_res flags no
// result left or incomplete inputs.
// Reset clears all counts and returns the registers to add, 16 x 16.
module sparse_triplet_matrix_engine_core #(
  parameter int MAX_DIM    = stme_pkg::MAX_DIM_DEF,
  parameter int MAX_NNZ    = stme_pkg::MAX_NNZ_DEF,
  parameter int VALUE_BITS = stme_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        action,
  input  logic                              matrix_sel,
  input  logic signed [stme_pkg::ELEM_W-1:0] element,
  input  logic                              wr_en,
  input  logic [stme_pkg::CIDX_W-1:0]       wr_index,
  input  logic [stme_pkg::CFG_W-1:0]        wr_data,
  output logic                              valid,
  output logic [stme_pkg::OIDX_W-1:0]       out_row,
  output logic [stme_pkg::OIDX_W-1:0]       out_col,
  output logic signed [stme_pkg::OUT_W-1:0] out_value,
  output logic                              last,
  output logic                              empty_res
);

  localparam int VB     = VALUE_BITS;
  localparam int OW     = stme_pkg::OUT_W;
  localparam int CW     = stme_pkg::CFG_W;
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int POS_W  = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int DCW    = $clog2(POS_W + 1);
  localparam int CNT_W  = $clog2(MAX_NNZ + 1);
  localparam int AW     = $clog2(MAX_NNZ);
  localparam int TRIP_W = 2 * IDX_W + VB;
  localparam int RES_W  = 2 * IDX_W + OW;
  localparam int PW     = 2 * VB;

  function automatic logic [DIM_W-1:0] dim_eff(input logic [CW-1:0] v);
    if (int'(v) > MAX_DIM) return DIM_W'(MAX_DIM);
    return DIM_W'(v);
  endfunction

  // configuration registers
  logic [1:0]    operation, operation_next;
  logic [CW-1:0] rows_a, rows_a_next, cols_a, cols_a_next;
  logic [CW-1:0] rows_b, rows_b_next, cols_b, cols_b_next;

  stme_pkg::state_t state, state_next;

  logic [POS_W-1:0] pos_a, pos_a_next, pos_b, pos_b_next;
  logic [CNT_W-1:0] cnt_a, cnt_a_next, cnt_b, cnt_b_next, cnt_res, cnt_res_next;
  logic [CNT_W-1:0] rd_ptr, rd_ptr_next;
  logic             computed, computed_next;
  logic             ld_sel, ld_sel_next;
  logic [VB-1:0]    ld_val, ld_val_next;
  logic [DIM_W-1:0] div_rem, div_rem_next;
  logic [POS_W-1:0] div_quo, div_quo_next;
  logic [DCW-1:0]   div_cnt, div_cnt_next;
  logic [CNT_W-1:0] i, i_next, j, j_next, p, p_next, q, q_next, run, run_next;
  logic [IDX_W-1:0] k, k_next, cur_r, cur_r_next, cur_c, cur_c_next;
  logic [OW-1:0]    sum, sum_next, prod, prod_next;

  logic                 valid_next, last_next, empty_next;
  logic [stme_pkg::OIDX_W-1:0] out_row_next, out_col_next;
  logic [OW-1:0]        out_value_next;

  // memories
  logic [TRIP_W-1:0] mem_a  [MAX_NNZ];
  logic [TRIP_W-1:0] mem_b  [MAX_NNZ];
  logic [TRIP_W-1:0] mem_bt [MAX_NNZ];
  logic [RES_W-1:0]  mem_rs [MAX_NNZ];
  logic [CNT_W-1:0]  mem_cm [MAX_DIM];

  logic              a_we, b_we, bt_we, rs_we, cm_we;
  logic [AW-1:0]     a_waddr, b_waddr, bt_waddr, rs_waddr;
  logic [IDX_W-1:0]  cm_waddr, cm_raddr;
  logic [TRIP_W-1:0] ab_wdata, bt_wdata;
  logic [RES_W-1:0]  rs_wdata;
  logic [CNT_W-1:0]  cm_wdata;
  logic              a_re, b_re, bt_re, rs_re, cm_re;
  logic [AW-1:0]     a_raddr, b_raddr, bt_raddr, rs_raddr;
  logic [TRIP_W-1:0] a_rd, b_rd, bt_rd;
  logic [RES_W-1:0]  rs_rd;
  logic [CNT_W-1:0]  cm_rd;

  always_ff @(posedge clk) begin
    if (a_we) mem_a[a_waddr] <= ab_wdata;
    if (b_we) mem_b[b_waddr] <= ab_wdata;
    if (bt_we) mem_bt[bt_waddr] <= bt_wdata;
    if (rs_we) mem_rs[rs_waddr] <= rs_wdata;
    if (cm_we) mem_cm[cm_waddr] <= cm_wdata;
    if (a_re) a_rd <= mem_a[a_raddr];
    if (b_re) b_rd <= mem_b[b_raddr];
    if (bt_re) bt_rd <= mem_bt[bt_raddr];
    if (rs_re) rs_rd <= mem_rs[rs_raddr];
    if (cm_re) cm_rd <= mem_cm[cm_raddr];
  end

  // triplet fields of the read data
  logic [IDX_W-1:0]      a_row, a_col, b_row, b_col, bt_row, bt_col;
  logic signed [VB-1:0]  a_val, b_val, bt_val;
  logic signed [VB:0]    add_sum;
  logic signed [PW-1:0]  mul;

  assign a_row  = a_rd[TRIP_W-1 -: IDX_W];
  assign a_col  = a_rd[VB+IDX_W-1 -: IDX_W];
  assign a_val  = a_rd[VB-1:0];
  assign b_row  = b_rd[TRIP_W-1 -: IDX_W];
  assign b_col  = b_rd[VB+IDX_W-1 -: IDX_W];
  assign b_val  = b_rd[VB-1:0];
  assign bt_row = bt_rd[TRIP_W-1 -: IDX_W];
  assign bt_col = bt_rd[VB+IDX_W-1 -: IDX_W];
  assign bt_val = bt_rd[VB-1:0];
  assign add_sum = a_val + b_val;
  assign mul     = a_val * bt_val;

  logic [DIM_W-1:0] rows_a_e, cols_a_e, rows_b_e, cols_b_e, div_cols;
  logic [POS_W-1:0] tot_a, tot_b;
  logic             full_a, full_b;
  logic [DIM_W:0]   rem_sh, rem_sub;
  logic             rem_ge;

  assign rows_a_e = dim_eff(rows_a);
  assign cols_a_e = dim_eff(cols_a);
  assign rows_b_e = dim_eff(rows_b);
  assign cols_b_e = dim_eff(cols_b);
  assign tot_a    = POS_W'(rows_a_e) * POS_W'(cols_a_e);
  assign tot_b    = POS_W'(rows_b_e) * POS_W'(cols_b_e);
  assign full_a   = pos_a >= tot_a;
  assign full_b   = pos_b >= tot_b;
  assign div_cols = ld_sel ? cols_b_e : cols_a_e;
  assign rem_sh   = {div_rem, div_quo[POS_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, div_cols};
  assign rem_sub  = rem_sh - {1'b0, div_cols};

  assign busy = (state != stme_pkg::S_IDLE);

  // result push request
  logic             psh;
  logic [IDX_W-1:0] psh_row, psh_col;
  logic [OW-1:0]    psh_val;

  always_comb begin
    state_next     = state;
    operation_next = operation;
    rows_a_next    = rows_a;
    cols_a_next    = cols_a;
    rows_b_next    = rows_b;
    cols_b_next    = cols_b;
    pos_a_next     = pos_a;
    pos_b_next     = pos_b;
    cnt_a_next     = cnt_a;
    cnt_b_next     = cnt_b;
    cnt_res_next   = cnt_res;
    rd_ptr_next    = rd_ptr;
    computed_next  = computed;
    ld_sel_next    = ld_sel;
    ld_val_next    = ld_val;
    div_rem_next   = div_rem;
    div_quo_next   = div_quo;
    div_cnt_next   = div_cnt;
    i_next = i; j_next = j; p_next = p; q_next = q; run_next = run;
    k_next = k; cur_r_next = cur_r; cur_c_next = cur_c;
    sum_next = sum; prod_next = prod;
    valid_next     = 1'b0;
    out_row_next   = out_row;
    out_col_next   = out_col;
    out_value_next = out_value;
    last_next      = last;
    empty_next     = empty_res;
    a_we = 1'b0; b_we = 1'b0; bt_we = 1'b0; rs_we = 1'b0; cm_we = 1'b0;
    a_waddr  = cnt_a[AW-1:0];
    b_waddr  = cnt_b[AW-1:0];
    ab_wdata = {div_quo[IDX_W-1:0], div_rem[IDX_W-1:0], ld_val};
    bt_waddr = cm_rd[AW-1:0];
    bt_wdata = {b_col, b_row, b_val};
    rs_waddr = cnt_res[AW-1:0];
    rs_wdata = '0;
    cm_waddr = k;
    cm_wdata = '0;
    a_re = 1'b0; b_re = 1'b0; bt_re = 1'b0; rs_re = 1'b0; cm_re = 1'b0;
    a_raddr  = i[AW-1:0];
    b_raddr  = j[AW-1:0];
    bt_raddr = j[AW-1:0];
    rs_raddr = rd_ptr[AW-1:0];
    cm_raddr = k;
    psh = 1'b0; psh_row = '0; psh_col = '0; psh_val = '0;

    case (state)
      stme_pkg::S_IDLE: begin
        if (start) begin
          case (action)
            stme_pkg::ACT_LOAD: begin
              computed_next = 1'b0;
              rd_ptr_next   = '0;
              ld_sel_next   = matrix_sel;
              ld_val_next   = VB'($unsigned(element));
              div_quo_next  = matrix_sel ? pos_b : pos_a;
              div_rem_next  = '0;
              div_cnt_next  = '0;
              // drop loads past the end of the matrix
              if (!(matrix_sel ? full_b : full_a)) state_next = stme_pkg::S_LD_DIV;
            end
            stme_pkg::ACT_FETCH: state_next = stme_pkg::S_F_CHK;
            stme_pkg::ACT_CLEAR: begin
              pos_a_next = '0; pos_b_next = '0;
              cnt_a_next = '0; cnt_b_next = '0; cnt_res_next = '0;
              rd_ptr_next = '0; computed_next = 1'b0;
            end
            default: ;
          endcase
        end
      end
      stme_pkg::S_LD_DIV: begin
        div_rem_next = rem_ge ? rem_sub[DIM_W-1:0] : rem_sh[DIM_W-1:0];
        div_quo_next = {div_quo[POS_W-2:0], rem_ge};
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DCW'(POS_W - 1)) state_next = stme_pkg::S_LD_WR;
      end
      stme_pkg::S_LD_WR: begin
        state_next = stme_pkg::S_IDLE;
        if (ld_sel) pos_b_next = pos_b + 1'b1;
        else pos_a_next = pos_a + 1'b1;
        if (ld_val != '0) begin
          if (ld_sel && cnt_b < CNT_W'(MAX_NNZ)) begin
            b_we = 1'b1;
            cnt_b_next = cnt_b + 1'b1;
          end else if (!ld_sel && cnt_a < CNT_W'(MAX_NNZ)) begin
            a_we = 1'b1;
            cnt_a_next = cnt_a + 1'b1;
          end
        end
      end
      stme_pkg::S_F_CHK: begin
        if ((!full_a && (operation == stme_pkg::OP_ADD ||
                         operation == stme_pkg::OP_MULTIPLY)) || !full_b) begin
          valid_next = 1'b1; empty_next = 1'b1; last_next = 1'b0;
          out_row_next = '0; out_col_next = '0; out_value_next = '0;
          state_next = stme_pkg::S_IDLE;
        end else if (computed) begin
          state_next = stme_pkg::S_F_RD;
        end else begin
          cnt_res_next = '0;
          rd_ptr_next  = '0;
          i_next = '0; j_next = '0; k_next = '0;
          case (operation)
            stme_pkg::OP_ADD:       state_next = stme_pkg::S_AD_RD;
            stme_pkg::OP_TRANSPOSE: state_next = stme_pkg::S_T_CLR;
            stme_pkg::OP_MULTIPLY:  state_next = stme_pkg::S_T_CLR;
            default: begin
              computed_next = 1'b1;
              state_next = stme_pkg::S_F_RD;
            end
          endcase
        end
      end
      stme_pkg::S_F_RD: begin
        if (rd_ptr >= cnt_res) begin
          valid_next = 1'b1; empty_next = 1'b1; last_next = 1'b0;
          out_row_next = '0; out_col_next = '0; out_value_next = '0;
          state_next = stme_pkg::S_IDLE;
        end else begin
          rs_re = 1'b1;
          state_next = stme_pkg::S_F_OUT;
        end
      end
      stme_pkg::S_F_OUT: begin
        valid_next     = 1'b1;
        empty_next     = 1'b0;
        out_row_next   = stme_pkg::OIDX_W'(rs_rd[RES_W-1 -: IDX_W]);
        out_col_next   = stme_pkg::OIDX_W'(rs_rd[OW+IDX_W-1 -: IDX_W]);
        out_value_next = rs_rd[OW-1:0];
        last_next      = (CNT_W'(rd_ptr + 1'b1) == cnt_res);
        rd_ptr_next    = rd_ptr + 1'b1;
        state_next     = stme_pkg::S_IDLE;
      end
      // transpose: clear column counts
      stme_pkg::S_T_CLR: begin
        cm_we = 1'b1;
        k_next = k + 1'b1;
        if (k == IDX_W'(MAX_DIM - 1)) begin
          i_next = '0;
          state_next = stme_pkg::S_T_CNT_RD;
        end
      end
      stme_pkg::S_T_CNT_RD: begin
        b_raddr = i[AW-1:0];
        if (i >= cnt_b) begin
          k_next = '0; run_next = '0;
          state_next = stme_pkg::S_T_PRE_RD;
        end else begin
          b_re = 1'b1;
          state_next = stme_pkg::S_T_CNT_GET;
        end
      end
      stme_pkg::S_T_CNT_GET: begin
        cm_re = 1'b1; cm_raddr = b_col;
        state_next = stme_pkg::S_T_CNT_WR;
      end
      stme_pkg::S_T_CNT_WR: begin
        cm_we = 1'b1; cm_waddr = b_col; cm_wdata = cm_rd + 1'b1;
        i_next = i + 1'b1;
        state_next = stme_pkg::S_T_CNT_RD;
      end
      // turn counts into column starts in place
      stme_pkg::S_T_PRE_RD: begin
        cm_re = 1'b1;
        state_next = stme_pkg::S_T_PRE_WR;
      end
      stme_pkg::S_T_PRE_WR: begin
        cm_we = 1'b1; cm_wdata = run;
        run_next = run + cm_rd;
        k_next = k + 1'b1;
        if (k == IDX_W'(MAX_DIM - 1)) begin
          i_next = '0;
          state_next = stme_pkg::S_T_PL_RD;
        end else begin
          state_next = stme_pkg::S_T_PRE_RD;
        end
      end
      stme_pkg::S_T_PL_RD: begin
        b_raddr = i[AW-1:0];
        if (i >= cnt_b) begin
          i_next = '0;
          state_next = (operation == stme_pkg::OP_TRANSPOSE) ? stme_pkg::S_CP_RD
                                                             : stme_pkg::S_M_ROW_RD;
        end else begin
          b_re = 1'b1;
          state_next = stme_pkg::S_T_PL_GET;
        end
      end
      stme_pkg::S_T_PL_GET: begin
        cm_re = 1'b1; cm_raddr = b_col;
        state_next = stme_pkg::S_T_PL_WR;
      end
      stme_pkg::S_T_PL_WR: begin
        bt_we = 1'b1;
        cm_we = 1'b1; cm_waddr = b_col; cm_wdata = cm_rd + 1'b1;
        i_next = i + 1'b1;
        state_next = stme_pkg::S_T_PL_RD;
      end
      // transpose result: copy B transposed out
      stme_pkg::S_CP_RD: begin
        bt_raddr = i[AW-1:0];
        if (i >= cnt_b) begin
          computed_next = 1'b1;
          state_next = stme_pkg::S_F_RD;
        end else begin
          bt_re = 1'b1;
          state_next = stme_pkg::S_CP_WR;
        end
      end
      stme_pkg::S_CP_WR: begin
        psh = 1'b1; psh_row = bt_row; psh_col = bt_col; psh_val = OW'(bt_val);
        i_next = i + 1'b1;
        state_next = stme_pkg::S_CP_RD;
      end
      // add: merge both lists in row-major order
      stme_pkg::S_AD_RD: begin
        a_re = 1'b1; b_re = 1'b1;
        state_next = stme_pkg::S_AD_CMP;
      end
      stme_pkg::S_AD_CMP: begin
        state_next = stme_pkg::S_AD_RD;
        if (i < cnt_a && j < cnt_b) begin
          psh = 1'b1;
          if ({a_row, a_col} == {b_row, b_col}) begin
            psh_row = a_row; psh_col = a_col; psh_val = OW'(add_sum);
            i_next = i + 1'b1; j_next = j + 1'b1;
          end else if ({a_row, a_col} < {b_row, b_col}) begin
            psh_row = a_row; psh_col = a_col; psh_val = OW'(a_val);
            i_next = i + 1'b1;
          end else begin
            psh_row = b_row; psh_col = b_col; psh_val = OW'(b_val);
            j_next = j + 1'b1;
          end
        end else if (i < cnt_a) begin
          psh = 1'b1; psh_row = a_row; psh_col = a_col; psh_val = OW'(a_val);
          i_next = i + 1'b1;
        end else if (j < cnt_b) begin
          psh = 1'b1; psh_row = b_row; psh_col = b_col; psh_val = OW'(b_val);
          j_next = j + 1'b1;
        end else begin
          computed_next = 1'b1;
          state_next = stme_pkg::S_F_RD;
        end
      end
      // multiply: row of A against each row of B transposed
      stme_pkg::S_M_ROW_RD: begin
        if (i >= cnt_a) begin
          computed_next = 1'b1;
          state_next = stme_pkg::S_F_RD;
        end else begin
          a_re = 1'b1;
          state_next = stme_pkg::S_M_ROW;
        end
      end
      stme_pkg::S_M_ROW: begin
        cur_r_next = a_row;
        j_next = '0;
        state_next = stme_pkg::S_M_COL_RD;
      end
      stme_pkg::S_M_COL_RD: begin
        if (j >= cnt_b) begin
          state_next = stme_pkg::S_M_ISK_RD;
        end else begin
          bt_re = 1'b1;
          state_next = stme_pkg::S_M_COL;
        end
      end
      stme_pkg::S_M_COL: begin
        cur_c_next = bt_row;
        p_next = i; q_next = j; sum_next = '0;
        state_next = stme_pkg::S_M_DOT_RD;
      end
      stme_pkg::S_M_DOT_RD: begin
        a_raddr = p[AW-1:0]; bt_raddr = q[AW-1:0];
        if (p < cnt_a && q < cnt_b) begin
          a_re = 1'b1; bt_re = 1'b1;
          state_next = stme_pkg::S_M_DOT_CMP;
        end else begin
          state_next = stme_pkg::S_M_PUSH;
        end
      end
      stme_pkg::S_M_DOT_CMP: begin
        state_next = stme_pkg::S_M_DOT_RD;
        if (a_row != cur_r || bt_row != cur_c) begin
          state_next = stme_pkg::S_M_PUSH;
        end else if (a_col < bt_col) begin
          p_next = p + 1'b1;
        end else if (a_col > bt_col) begin
          q_next = q + 1'b1;
        end else begin
          prod_next = OW'(mul);
          p_next = p + 1'b1; q_next = q + 1'b1;
          state_next = stme_pkg::S_M_DOT_ACC;
        end
      end
      stme_pkg::S_M_DOT_ACC: begin
        sum_next = sum + prod;
        state_next = stme_pkg::S_M_DOT_RD;
      end
      stme_pkg::S_M_PUSH: begin
        // drop zero sums
        psh = (sum != '0); psh_row = cur_r; psh_col = cur_c; psh_val = sum;
        state_next = stme_pkg::S_M_JSK_RD;
      end
      stme_pkg::S_M_JSK_RD: begin
        if (j < cnt_b) begin
          bt_re = 1'b1;
          state_next = stme_pkg::S_M_JSK;
        end else begin
          state_next = stme_pkg::S_M_COL_RD;
        end
      end
      stme_pkg::S_M_JSK: begin
        if (bt_row == cur_c) begin
          j_next = j + 1'b1;
          state_next = stme_pkg::S_M_JSK_RD;
        end else begin
          state_next = stme_pkg::S_M_COL_RD;
        end
      end
      stme_pkg::S_M_ISK_RD: begin
        if (i < cnt_a) begin
          a_re = 1'b1;
          state_next = stme_pkg::S_M_ISK;
        end else begin
          state_next = stme_pkg::S_M_ROW_RD;
        end
      end
      stme_pkg::S_M_ISK: begin
        if (a_row == cur_r) begin
          i_next = i + 1'b1;
          state_next = stme_pkg::S_M_ISK_RD;
        end else begin
          state_next = stme_pkg::S_M_ROW_RD;
        end
      end
      default: state_next = stme_pkg::S_IDLE;
    endcase

    // keep results up to the store size
    if (psh && cnt_res < CNT_W'(MAX_NNZ)) begin
      rs_we = 1'b1;
      rs_wdata = {psh_row, psh_col, psh_val};
      cnt_res_next = cnt_res + 1'b1;
    end

    // register writes discard any built result
    if (wr_en) begin
      case (wr_index)
        stme_pkg::REG_OPERATION: operation_next = wr_data[1:0];
        stme_pkg::REG_ROWS_A:    rows_a_next = wr_data;
        stme_pkg::REG_COLS_A:    cols_a_next = wr_data;
        stme_pkg::REG_ROWS_B:    rows_b_next = wr_data;
        stme_pkg::REG_COLS_B:    cols_b_next = wr_data;
        default: ;
      endcase
      if (wr_index <= stme_pkg::REG_COLS_B) begin
        computed_next = 1'b0;
        rd_ptr_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stme_pkg::S_IDLE;
      operation <= stme_pkg::OP_ADD;
      rows_a    <= CW'(16);
      cols_a    <= CW'(16);
      rows_b    <= CW'(16);
      cols_b    <= CW'(16);
      pos_a     <= '0;
      pos_b     <= '0;
      cnt_a     <= '0;
      cnt_b     <= '0;
      cnt_res   <= '0;
      rd_ptr    <= '0;
      computed  <= 1'b0;
      valid     <= 1'b0;
    end else begin
      state     <= state_next;
      operation <= operation_next;
      rows_a    <= rows_a_next;
      cols_a    <= cols_a_next;
      rows_b    <= rows_b_next;
      cols_b    <= cols_b_next;
      pos_a     <= pos_a_next;
      pos_b     <= pos_b_next;
      cnt_a     <= cnt_a_next;
      cnt_b     <= cnt_b_next;
      cnt_res   <= cnt_res_next;
      rd_ptr    <= rd_ptr_next;
      computed  <= computed_next;
      valid     <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ld_sel    <= ld_sel_next;
    ld_val    <= ld_val_next;
    div_rem   <= div_rem_next;
    div_quo   <= div_quo_next;
    div_cnt   <= div_cnt_next;
    i         <= i_next;
    j         <= j_next;
    p         <= p_next;
    q         <= q_next;
    run       <= run_next;
    k         <= k_next;
    cur_r     <= cur_r_next;
    cur_c     <= cur_c_next;
    sum       <= sum_next;
    prod      <= prod_next;
    out_row   <= out_row_next;
    out_col   <= out_col_next;
    out_value <= out_value_next;
    last      <= last_next;
    empty_res <= empty_next;
  end

endmodule

/* hw/rtl/stme_checker.sv */
`timescale 1ns / 1ps

module stme_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic [1:0]                        action,
  input logic                              valid,
  input logic [stme_pkg::OIDX_W-1:0]       out_row,
  input logic [stme_pkg::OIDX_W-1:0]       out_col,
  input logic signed [stme_pkg::OUT_W-1:0] out_value,
  input logic                              last,
  input logic                              empty_res
);

  // an empty answer carries no triplet
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && empty_res) |-> (!last && out_value == '0 && out_row == '0 && out_col == '0))
    else $error("empty result carries data");

  // one result per fetch, never two in a row
  a_single: assert property (@(posedge clk) disable iff (rst) valid |=> !valid)
    else $error("result strobe held");

  // a fetch that transfers always makes the block busy in the next cycle
  a_fetch_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == stme_pkg::ACT_FETCH) |=> busy)
    else $error("fetch not taken up");

  a_reset: assert property (@(posedge clk) rst |=> (!valid && !busy))
    else $error("not idle after reset");

endmodule

bind sparse_triplet_matrix_engine_core stme_checker u_stme_checker (.*);

/* dv/tb_sparse_triplet_matrix_engine_core.sv */
`timescale 1ns / 1ps

module tb_sparse_triplet_matrix_engine_core;

  localparam int NNZ      = 256;
  localparam int DIMS     = 16;
  localparam int N_ITEMS  = 1550;
  localparam int STALL_LIM = 400000;
  localparam logic [1:0] ACT_NONE = 2'd3;      // unused action code, must be ignored
  localparam logic [1:0] OP_NONE  = 2'd3;      // unused operation code, empty result
  localparam logic [39:0] VMASK = {40{1'b1}};

  typedef struct packed {
    logic [3:0]  row;
    logic [3:0]  col;
    logic [39:0] value;
    logic        last;
    logic        empty;
  } triplet_out_t;

  typedef enum logic {ROW_REG, ROW_CMD} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [stme_pkg::CIDX_W-1:0] idx;
    logic [stme_pkg::CFG_W-1:0]  data;
    logic [1:0]                  act;
    logic                        sel;
    logic [15:0]                 elem;
    bit                          typed;
    triplet_out_t                res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action = stme_pkg::ACT_LOAD;
  logic matrix_sel = 1'b0;
  logic signed [stme_pkg::ELEM_W-1:0] element = '0;
  logic wr_en = 1'b0;
  logic [stme_pkg::CIDX_W-1:0] wr_index = '0;
  logic [stme_pkg::CFG_W-1:0] wr_data = '0;
  logic valid;
  logic [stme_pkg::OIDX_W-1:0] out_row, out_col;
  logic signed [stme_pkg::OUT_W-1:0] out_value;
  logic last, empty_res;

  sparse_triplet_matrix_engine_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .matrix_sel(matrix_sel), .element(element),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .valid(valid), .out_row(out_row), .out_col(out_col), .out_value(out_value),
    .last(last), .empty_res(empty_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Triplet store model: registers, stores, counts and the built result list.
  // ---------------------------------------------------------------------------
  logic [1:0] m_op;
  int m_rows_a, m_cols_a, m_rows_b, m_cols_b;
  int a_row[NNZ], a_col[NNZ], b_row[NNZ], b_col[NNZ];
  int t_row[NNZ], t_col[NNZ], r_row[NNZ], r_col[NNZ];
  logic [39:0] a_val[NNZ], b_val[NNZ], t_val[NNZ], r_val[NNZ];
  int n_a, n_b, n_res, fill_a, fill_b, rd_ptr;
  bit built;
  bit last_was_empty;

  triplet_out_t pending_q[$];
  int n_sent, n_errors;
  bit timed_out;

  function automatic int clip_dim(int v);
    return v > DIMS ? DIMS : v;
  endfunction

  function automatic void model_reset();
    m_op = stme_pkg::OP_ADD;
    m_rows_a = 16; m_cols_a = 16; m_rows_b = 16; m_cols_b = 16;
    n_a = 0; n_b = 0; n_res = 0; fill_a = 0; fill_b = 0; rd_ptr = 0;
    built = 0;
  endfunction

  function automatic void model_write_reg(logic [stme_pkg::CIDX_W-1:0] idx,
                                          logic [stme_pkg::CFG_W-1:0] d);
    case (idx)
      stme_pkg::REG_OPERATION: m_op = d[1:0];
      stme_pkg::REG_ROWS_A:    m_rows_a = int'(d);
      stme_pkg::REG_COLS_A:    m_cols_a = int'(d);
      stme_pkg::REG_ROWS_B:    m_rows_b = int'(d);
      stme_pkg::REG_COLS_B:    m_cols_b = int'(d);
      default:                 return;
    endcase
    built = 0;
    rd_ptr = 0;
  endfunction

  function automatic void model_load(logic sel, logic [15:0] raw);
    int rows, cols, r, c;
    logic [39:0] v;
    rows = clip_dim(sel ? m_rows_b : m_rows_a);
    cols = clip_dim(sel ? m_cols_b : m_cols_a);
    v = {{24{raw[15]}}, raw};
    built = 0;
    rd_ptr = 0;
    if (sel) begin
      if (fill_b >= rows * cols) return;
      r = fill_b / cols; c = fill_b % cols; fill_b++;
      if (v != 0 && n_b < NNZ) begin
        b_row[n_b] = r; b_col[n_b] = c; b_val[n_b] = v; n_b++;
      end
    end else begin
      if (fill_a >= rows * cols) return;
      r = fill_a / cols; c = fill_a % cols; fill_a++;
      if (v != 0 && n_a < NNZ) begin
        a_row[n_a] = r; a_col[n_a] = c; a_val[n_a] = v; n_a++;
      end
    end
  endfunction

  function automatic void push_result(int r, int c, logic [39:0] v);
    if (n_res < NNZ) begin
      r_row[n_res] = r; r_col[n_res] = c; r_val[n_res] = v; n_res++;
    end
  endfunction

  // Counting sort of B by column into the transposed store.
  function automatic void transpose_into_t();
    int cnt[DIMS], first[DIMS];
    int c, loc;
    foreach (cnt[k]) cnt[k] = 0;
    for (int i = 0; i < n_b; i++) cnt[b_col[i] % DIMS]++;
    first[0] = 0;
    for (int k = 1; k < DIMS; k++) first[k] = first[k-1] + cnt[k-1];
    for (int i = 0; i < n_b; i++) begin
      c = b_col[i] % DIMS;
      loc = first[c]++;
      if (loc < NNZ) begin
        t_row[loc] = c; t_col[loc] = b_row[i]; t_val[loc] = b_val[i];
      end
    end
  endfunction

  function automatic void build_sum();
    int i, j, ka, kb;
    i = 0; j = 0;
    while (i < n_a && j < n_b) begin
      ka = a_row[i] * DIMS + a_col[i];
      kb = b_row[j] * DIMS + b_col[j];
      if (ka == kb) begin
        push_result(a_row[i], a_col[i], a_val[i] + b_val[j]); i++; j++;
      end else if (ka < kb) begin
        push_result(a_row[i], a_col[i], a_val[i]); i++;
      end else begin
        push_result(b_row[j], b_col[j], b_val[j]); j++;
      end
    end
    for (; i < n_a; i++) push_result(a_row[i], a_col[i], a_val[i]);
    for (; j < n_b; j++) push_result(b_row[j], b_col[j], b_val[j]);
  endfunction

  function automatic void build_product();
    int i, j, p, q, r, c;
    logic [39:0] acc;
    transpose_into_t();
    i = 0;
    while (i < n_a) begin
      r = a_row[i]; j = 0;
      while (j < n_b) begin
        c = t_row[j]; p = i; q = j; acc = '0;
        while (p < n_a && a_row[p] == r && q < n_b && t_row[q] == c) begin
          if (a_col[p] < t_col[q]) p++;
          else if (a_col[p] > t_col[q]) q++;
          else begin
            acc += a_val[p] * t_val[q]; p++; q++;
          end
        end
        if (acc != 0) push_result(r, c, acc);
        while (j < n_b && t_row[j] == c) j++;
      end
      while (i < n_a && a_row[i] == r) i++;
    end
  endfunction

  function automatic triplet_out_t model_fetch();
    triplet_out_t o;
    o = '0;
    o.empty = 1'b1;
    if (((m_op == stme_pkg::OP_ADD || m_op == stme_pkg::OP_MULTIPLY) &&
         fill_a < clip_dim(m_rows_a) * clip_dim(m_cols_a)) ||
        fill_b < clip_dim(m_rows_b) * clip_dim(m_cols_b))
      return o;
    if (!built) begin
      n_res = 0; rd_ptr = 0;
      case (m_op)
        stme_pkg::OP_ADD: build_sum();
        stme_pkg::OP_TRANSPOSE: begin
          transpose_into_t();
          for (int i = 0; i < n_b; i++) push_result(t_row[i], t_col[i], t_val[i]);
        end
        stme_pkg::OP_MULTIPLY: build_product();
        default: ;
      endcase
      built = 1;
    end
    if (rd_ptr >= n_res) return o;
    o.row = r_row[rd_ptr][3:0];
    o.col = r_col[rd_ptr][3:0];
    o.value = r_val[rd_ptr] & VMASK;
    o.last = (rd_ptr + 1 == n_res);
    o.empty = 1'b0;
    rd_ptr++;
    return o;
  endfunction

  // Advance the model on one accepted command; return 1 if a result follows.
  function automatic bit model_command(logic [1:0] act, logic sel, logic [15:0] el,
                                       output triplet_out_t o);
    o = '0;
    case (act)
      stme_pkg::ACT_LOAD: model_load(sel, el);
      stme_pkg::ACT_CLEAR: begin
        n_a = 0; n_b = 0; n_res = 0; fill_a = 0; fill_b = 0; rd_ptr = 0; built = 0;
      end
      stme_pkg::ACT_FETCH: begin
        o = model_fetch();
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving: change inputs on the falling edge, sample on the rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(logic [1:0] act, logic sel, logic [15:0] el,
                          bit typed, triplet_out_t typed_res);
    int idle_pct;
    triplet_out_t o;
    bit has_res;
    idle_pct = n_sent < N_ITEMS / 3 ? 9 : (n_sent < 2 * N_ITEMS / 3 ? 47 : 0);
    // hold start low for a random gap at the sender's idle rate
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1; action = act; matrix_sel = sel; element = el;
    // busy only moves on the rising edge, so it is stable here
    while (busy) @(negedge clk);
    @(posedge clk);
    has_res = model_command(act, sel, el, o);
    if (typed) o = typed_res;
    if (has_res) begin
      pending_q.push_back(o);
      last_was_empty = o.empty;
    end
    n_sent++;
  endtask

  // Drop start and let the block drain before a register write.
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_q.size() != 0 || busy) @(negedge clk);
    // a load gives no result, so allow for its divider latency
    repeat (24) @(negedge clk);
  endtask

  task automatic write_reg(logic [stme_pkg::CIDX_W-1:0] idx,
                           logic [stme_pkg::CFG_W-1:0] d);
    @(negedge clk);
    wr_en = 1'b1; wr_index = idx; wr_data = d;
    @(negedge clk);
    wr_en = 1'b0;
    model_write_reg(idx, d);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and the stall watchdog.
  // ---------------------------------------------------------------------------
  int stall_cycles;

  always @(posedge clk) begin
    triplet_out_t want, got;
    if (!rst) begin
      if ((start && !busy) || valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (valid) begin
        got = '{row: out_row, col: out_col, value: out_value, last: last,
                empty: empty_res};
        if (pending_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: unexpected result row %0d col %0d value %0d",
                     out_row, out_col, out_value);
        end else begin
          want = pending_q.pop_front();
          if (got != want) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: exp r%0d c%0d v%0d l%0b e%0b got r%0d c%0d v%0d l%0b e%0b",
                       want.row, want.col, $signed(want.value), want.last, want.empty,
                       got.row, got.col, $signed(got.value), got.last, got.empty);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && stall_cycles >= STALL_LIM && !timed_out) begin
      timed_out = 1'b1;
      $display("ERROR: no transfer for %0d cycles", STALL_LIM);
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows[$];

  function automatic stim_row_t reg_row(logic [stme_pkg::CIDX_W-1:0] idx,
                                        logic [stme_pkg::CFG_W-1:0] d);
    stim_row_t s;
    s = '{kind: ROW_REG, idx: idx, data: d, act: stme_pkg::ACT_LOAD, sel: 1'b0,
          elem: '0, typed: 1'b0, res: '0};
    return s;
  endfunction

  function automatic stim_row_t cmd_row(logic [1:0] act, logic sel, logic [15:0] el);
    stim_row_t s;
    s = '{kind: ROW_CMD, idx: stme_pkg::REG_OPERATION, data: '0, act: act, sel: sel,
          elem: el, typed: 1'b0, res: '0};
    return s;
  endfunction

  function automatic stim_row_t fetch_typed(int r, int c, logic [39:0] v, bit l, bit e);
    stim_row_t s;
    s = cmd_row(stme_pkg::ACT_FETCH, 1'b0, 16'd0);
    s.typed = 1'b1;
    s.res = '{row: 4'(r), col: 4'(c), value: v, last: l, empty: e};
    return s;
  endfunction

  function automatic logic [15:0] pick_element();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'h0000;
      4: return 16'h7fff;
      5: return 16'h8000;
      6: return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [stme_pkg::CFG_W-1:0] pick_dim();
    int k;
    k = $urandom_range(0, 39);
    if (k == 0) return stme_pkg::CFG_W'(16);
    if (k == 1) return stme_pkg::CFG_W'($urandom_range(0, 31));
    return stme_pkg::CFG_W'($urandom_range(1, 4));
  endfunction

  // Occasional noise inside a data set: early fetch or an unused action.
  task automatic maybe_noise();
    case ($urandom_range(0, 39))
      0: send_cmd(stme_pkg::ACT_FETCH, 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)), 1'b0, '0);
      1: send_cmd(ACT_NONE, 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)), 1'b0, '0);
      default: ;
    endcase
  endtask

  // Data set: set registers, load A (at times skipped for transpose) and B, fetch the result.
  task automatic run_data_set();
    logic [1:0] op;
    int fill_goal_a, fill_goal_b, guard;
    op = ($urandom_range(0, 14) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
    wait_idle();
    write_reg(stme_pkg::REG_OPERATION, stme_pkg::CFG_W'(op));
    write_reg(stme_pkg::REG_ROWS_A, pick_dim());
    write_reg(stme_pkg::REG_COLS_A, pick_dim());
    write_reg(stme_pkg::REG_ROWS_B, pick_dim());
    write_reg(stme_pkg::REG_COLS_B, pick_dim());
    send_cmd(stme_pkg::ACT_CLEAR, 1'($urandom_range(0, 1)),
             16'($urandom_range(0, 65535)), 1'b0, '0);
    fill_goal_a = clip_dim(m_rows_a) * clip_dim(m_cols_a) + $urandom_range(0, 1);
    fill_goal_b = clip_dim(m_rows_b) * clip_dim(m_cols_b) + $urandom_range(0, 1);
    if (op == stme_pkg::OP_TRANSPOSE && $urandom_range(0, 1)) fill_goal_a = 0;
    for (int k = 0; k < fill_goal_a; k++) begin
      maybe_noise();
      send_cmd(stme_pkg::ACT_LOAD, 1'b0, pick_element(), 1'b0, '0);
    end
    for (int k = 0; k < fill_goal_b; k++) begin
      maybe_noise();
      send_cmd(stme_pkg::ACT_LOAD, 1'b1, pick_element(), 1'b0, '0);
    end
    // a rare clear mid-set leaves the inputs incomplete
    if ($urandom_range(0, 49) == 0)
      send_cmd(stme_pkg::ACT_CLEAR, 1'($urandom_range(0, 1)),
               16'($urandom_range(0, 65535)), 1'b0, '0);
    guard = 0;
    last_was_empty = 0;
    while (!last_was_empty && guard < 300) begin
      // now and then switch the operation part way through the read-out
      if (guard > 0 && $urandom_range(0, 59) == 0) begin
        wait_idle();
        write_reg(stme_pkg::REG_OPERATION, stme_pkg::CFG_W'($urandom_range(0, 2)));
      end
      send_cmd(stme_pkg::ACT_FETCH, 1'($urandom_range(0, 1)),
               16'($urandom_range(0, 65535)), 1'b0, '0);
      guard++;
    end
    if ($urandom_range(0, 1))
      send_cmd(stme_pkg::ACT_FETCH, 1'($urandom_range(0, 1)),
               16'($urandom_range(0, 65535)), 1'b0, '0);
  endtask

  initial begin
    model_reset();
    n_sent = 0;
    n_errors = 0;
    stall_cycles = 0;
    timed_out = 0;
    last_was_empty = 0;

    // Directed table: extremes, every action and operation, the odd cases.
    dir_rows.push_back(fetch_typed(0, 0, 40'd0, 1'b0, 1'b1));   // nothing loaded yet
    dir_rows.push_back(reg_row(stme_pkg::REG_OPERATION,
                               stme_pkg::CFG_W'(stme_pkg::OP_TRANSPOSE)));
    dir_rows.push_back(reg_row(stme_pkg::REG_ROWS_B, stme_pkg::CFG_W'(1)));
    dir_rows.push_back(reg_row(stme_pkg::REG_COLS_B, stme_pkg::CFG_W'(2)));
    dir_rows.push_back(cmd_row(stme_pkg::ACT_LOAD, 1'b1, 16'h7fff));
    dir_rows.push_back(cmd_row(stme_pkg::ACT_LOAD, 1'b1, 16'h8000));
    dir_rows.push_back(cmd_row(stme_pkg::ACT_LOAD, 1'b1, 16'h0005));  // past the end, ignored
    dir_rows.push_back(fetch_typed(0, 0, 40'd32767, 1'b0, 1'b0));
    dir_rows.push_back(fetch_typed(1, 0, 40'hff_ffff_8000, 1'b1, 1'b0));
    dir_rows.push_back(fetch_typed(0, 0, 40'd0, 1'b0, 1'b1));   // read out completely
    dir_rows.push_back(cmd_row(ACT_NONE, 1'b1, 16'hffff));
    dir_rows.push_back(reg_row(stme_pkg::REG_OPERATION,
                               stme_pkg::CFG_W'(stme_pkg::OP_ADD)));
    dir_rows.push_back(reg_row(stme_pkg::REG_ROWS_A, stme_pkg::CFG_W'(1)));
    dir_rows.push_back(reg_row(stme_pkg::REG_COLS_A, stme_pkg::CFG_W'(2)));
    dir_rows.push_back(cmd_row(stme_pkg::ACT_LOAD, 1'b0, 16'h8001));  // cancels B to zero
    dir_rows.push_back(cmd_row(stme_pkg::ACT_LOAD, 1'b0, 16'h0000));
    dir_rows.push_back(cmd_row(stme_pkg::ACT_FETCH, 1'b0, 16'd0));
    dir_rows.push_back(cmd_row(stme_pkg::ACT_FETCH, 1'b1, 16'd0));
    dir_rows.push_back(reg_row(stme_pkg::REG_OPERATION,
                               stme_pkg::CFG_W'(stme_pkg::OP_MULTIPLY)));
    dir_rows.push_back(cmd_row(stme_pkg::ACT_FETCH, 1'b0, 16'd0));
    dir_rows.push_back(cmd_row(stme_pkg::ACT_FETCH, 1'b0, 16'd0));
    dir_rows.push_back(cmd_row(stme_pkg::ACT_CLEAR, 1'b0, 16'd0));
    dir_rows.push_back(fetch_typed(0, 0, 40'd0, 1'b0, 1'b1));   // inputs incomplete
    dir_rows.push_back(reg_row(stme_pkg::REG_ROWS_A, stme_pkg::CFG_W'(0)));  // zero-sized A
    dir_rows.push_back(reg_row(stme_pkg::REG_OPERATION, stme_pkg::CFG_W'(OP_NONE)));
    dir_rows.push_back(cmd_row(stme_pkg::ACT_LOAD, 1'b1, 16'h1234));
    dir_rows.push_back(cmd_row(stme_pkg::ACT_LOAD, 1'b1, 16'hedcb));
    dir_rows.push_back(fetch_typed(0, 0, 40'd0, 1'b0, 1'b1));   // unused operation
    dir_rows.push_back(reg_row(stme_pkg::REG_ROWS_A, stme_pkg::CFG_W'(31)));  // saturates
    dir_rows.push_back(reg_row(stme_pkg::REG_COLS_B, stme_pkg::CFG_W'(31)));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == ROW_REG) begin
        wait_idle();
        write_reg(dir_rows[n].idx, dir_rows[n].data);
      end else begin
        send_cmd(dir_rows[n].act, dir_rows[n].sel, dir_rows[n].elem,
                 dir_rows[n].typed, dir_rows[n].res);
      end
    end

    // Random data sets until the item budget is spent.
    while (n_sent < N_ITEMS) run_data_set();

    @(negedge clk);
    start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/stme_pkg.sv
hw/rtl/sparse_triplet_matrix_engine_core.sv
hw/rtl/stme_checker.sv
dv/tb_sparse_triplet_matrix_engine_core.sv
